>>> rtl/csss_pkg.sv
// Shared types, constants and helpers for the cumulative-sum spike sampler.
// No dependencies; imported by every module of the block.
package csss_pkg;

   localparam int FIX_W = 49;
   localparam logic [FIX_W-1:0] FIX_MAX = {FIX_W{1'b1}};

   // Config register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_VECTOR_SIZE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAYER_SIZE  = 1'b1;
   localparam int CSR_DATA_W = 16;

   typedef struct packed {
      logic             valid;  // random value selects something
      logic [FIX_W-1:0] level;
   } rand_type;

   typedef struct packed {
      logic [FIX_W-1:0] sum;      // running sum after this word
      logic             selected; // selection done after this word
      logic             hit;      // a selection happened in this word
      logic             hit_high; // the high half made the selection
   } select_type;

   // Code c: (2048 + c[10:0]) << c[15:11], exact in the fixed-point format.
   function automatic logic [FIX_W-1:0] code_value(input logic [15:0] code);
      logic [FIX_W-1:0] mant;
      mant = FIX_W'({1'b1, code[10:0]});
      return mant << code[15:11];
   endfunction

endpackage

>>> rtl/csss_rand_conv.sv
// Converts a float32 random word to the 49-bit fixed-point level, rounding up.
// Depends on csss_pkg.
module csss_rand_conv
   import csss_pkg::*;
(
   input  logic [31:0] word,
   output rand_type    rand_out
);

   logic        sign;
   logic [7:0]  ex;
   logic [22:0] man;
   logic [23:0] sig;
   logic [7:0]  up_sh;
   logic [7:0]  dn_sh;
   logic [23:0] quot;
   logic [23:0] low_mask;
   logic        rem;

   assign sign     = word[31];
   assign ex       = word[30:23];
   assign man      = word[22:0];
   assign sig      = {1'b1, man};
   assign up_sh    = ex - 8'd108;
   assign dn_sh    = 8'd108 - ex;
   assign quot     = sig >> dn_sh[4:0];
   assign low_mask = ~(24'hFF_FFFF << dn_sh[4:0]);
   assign rem      = |(sig & low_mask);

   always_comb begin
      rand_out.valid = 1'b1;
      rand_out.level = FIX_W'(1);
      if (sign || (ex == 8'd0 && man == 23'd0)) begin
         rand_out.valid = 1'b0;
         rand_out.level = '0;
      end else if (ex == 8'hFF) begin
         rand_out.valid = (man == 23'd0);
         rand_out.level = (man == 23'd0) ? FIX_MAX : '0;
      end else if (ex == 8'd0) begin
         rand_out.level = FIX_W'(1);
      end else if (ex >= 8'd108) begin
         if (up_sh > 8'd25) begin
            rand_out.level = FIX_MAX;
         end else begin
            rand_out.level = FIX_W'(sig) << up_sh[4:0];
         end
      end else if (dn_sh >= 8'd25) begin
         rand_out.level = FIX_W'(1);
      end else begin
         rand_out.level = FIX_W'(quot) + FIX_W'(rem);
      end
   end

endmodule

>>> rtl/csss_pair_select.sv
// Adds the two probability codes of one word to the running sum and finds
// the selecting half, if any. Depends on csss_pkg.
module csss_pair_select
   import csss_pkg::*;
#(
   parameter int IW = 7
)
(
   input  logic [31:0]    word,
   input  logic [IW-1:0]  base_idx,    // index of the low half
   input  logic [IW-1:0]  elem_count,  // effective vector size
   input  logic [FIX_W-1:0] level,
   input  logic [FIX_W-1:0] sum,
   input  logic           selected,
   output select_type     sel_out
);

   logic [IW-1:0]    idx_hi;
   logic [IW-1:0]    idx_last;
   logic             act_lo, act_hi;
   logic [FIX_W:0]   raw_lo, raw_hi;
   logic [FIX_W-1:0] sum_lo, sum_hi, sum_mid;
   logic             hit_lo, hit_hi;

   assign idx_hi   = base_idx + IW'(1);
   assign idx_last = elem_count - IW'(1);

   // Low half
   assign act_lo  = (base_idx < elem_count) && !selected;
   assign raw_lo  = {1'b0, sum} + {1'b0, code_value(word[15:0])};
   assign sum_lo  = raw_lo[FIX_W] ? FIX_MAX : raw_lo[FIX_W-1:0];
   assign hit_lo  = act_lo && ((level <= sum_lo) || (base_idx == idx_last));
   assign sum_mid = act_lo ? sum_lo : sum;

   // High half sees the low half's outcome
   assign act_hi  = (idx_hi < elem_count) && !selected && !hit_lo;
   assign raw_hi  = {1'b0, sum_mid} + {1'b0, code_value(word[31:16])};
   assign sum_hi  = raw_hi[FIX_W] ? FIX_MAX : raw_hi[FIX_W-1:0];
   assign hit_hi  = act_hi && ((level <= sum_hi) || (idx_hi == idx_last));

   always_comb begin
      sel_out.sum      = act_hi ? sum_hi : sum_mid;
      sel_out.selected = selected || hit_lo || hit_hi;
      sel_out.hit      = hit_lo || hit_hi;
      sel_out.hit_high = hit_hi;
   end

endmodule

>>> rtl/cumulative_sum_spike_sampler.sv
// Top level of the cumulative-sum spike sampler: stream ports, config
// registers, frame sequencing and output register. Depends on csss_pkg,
// csss_rand_conv and csss_pair_select.
//
// The block walks a frame word stream: per position one float32 random word,
// then ceil(n/2) words of two 16-bit probability codes (low half first),
// where n is vector_size limited to MAX_ELEMENTS. Codes and the random value
// are compared in exact 49-bit fixed point (42 fraction bits); the first
// index whose running sum reaches the random value is chosen, else the last,
// and a non-positive or NaN random selects nothing. Indices pack two per
// output transaction: even positions in bits 15..0, odd positions in bits
// 31..16. A transaction leaves at the code word where an odd or final
// position selects; rsp_tlast marks the final position of the frame. A word
// sits in the input register while the random conversion or the two
// saturating adds and compares run, and the outcome lands in the state and
// output registers. Throughput is one word per clock while the result side
// keeps up. While a result waits in the output register and rsp_tready is
// low, the held word does not advance, whether or not it would emit; one more
// word can still enter an empty input register, after that req_tready drops
// until the result is taken. Write csr_* only while the stream is idle.
module cumulative_sum_spike_sampler
   import csss_pkg::*;
#(
   parameter int MAX_ELEMENTS = 64
)
(
   input  logic                  clock,
   input  logic                  reset,
   // Input stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,   // [31:0] stream_word
   // Result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,   // [31:0] spike_pair
   output logic                  rsp_tlast,   // last_word
   // Config writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int NW = $clog2(MAX_ELEMENTS + 1);
   localparam int PW = $clog2(((MAX_ELEMENTS + 1) / 2) + 1);
   localparam int IW = PW + 1;

   // Config registers
   logic [6:0]   vec_size_ff;
   logic [15:0]  layer_size_ff;

   // Input register
   logic         in_valid_ff;
   logic [31:0]  in_word_ff;

   // Sequencing state
   logic [PW-1:0]    phase_ff,    phase_in;
   logic [15:0]      pos_ff,      pos_in;
   logic [FIX_W-1:0] level_ff,    level_in;
   logic [FIX_W-1:0] sum_ff,      sum_in;
   logic             sel_ff,      sel_in;
   logic [31:0]      pair_ff,     pair_in;

   // Output register
   logic         out_valid_ff;
   logic [31:0]  out_pair_ff;
   logic         out_last_ff;

   logic         advance;
   logic         emit;
   logic [NW-1:0] elem_count;
   logic [PW-1:0] word_count;
   logic [15:0]  layer_eff;
   logic         final_pos;
   logic         odd_pos;
   logic         end_pos;
   logic [IW-1:0] base_idx;
   logic [IW-1:0] hit_idx;
   rand_type     rand_val;
   select_type   sel_val;

   // Process the held word when the output register can take a result
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Clamp vector size to MAX_ELEMENTS; a zero layer size counts as one
   assign elem_count = (32'(vec_size_ff) > 32'(MAX_ELEMENTS)) ? NW'(MAX_ELEMENTS)
                                                              : NW'(vec_size_ff);
   assign word_count = PW'((IW'(elem_count) + IW'(1)) >> 1);
   assign layer_eff  = (layer_size_ff == 16'd0) ? 16'd1 : layer_size_ff;
   assign final_pos  = ({1'b0, pos_ff} + 17'd1) >= {1'b0, layer_eff};
   assign odd_pos    = pos_ff[0];
   assign base_idx   = {phase_ff - PW'(1), 1'b0};
   assign hit_idx    = sel_val.hit_high ? (base_idx + IW'(1)) : base_idx;

   csss_rand_conv u_rand_conv (
      .word     (in_word_ff),
      .rand_out (rand_val)
   );

   csss_pair_select #(
      .IW (IW)
   ) u_pair_select (
      .word       (in_word_ff),
      .base_idx   (base_idx),
      .elem_count (IW'(elem_count)),
      .level      (level_ff),
      .sum        (sum_ff),
      .selected   (sel_ff),
      .sel_out    (sel_val)
   );

   // Next state for one word
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      level_in = level_ff;
      sum_in   = sum_ff;
      sel_in   = sel_ff;
      pair_in  = pair_ff;
      emit     = 1'b0;
      end_pos  = 1'b0;
      if (phase_ff == '0) begin
         // Random word opens the position
         level_in = rand_val.level;
         sum_in   = '0;
         sel_in   = !rand_val.valid;
         if (pos_ff == 16'd0) begin
            pair_in = '0;
         end
         if (word_count == '0) begin
            end_pos = 1'b1;
         end else begin
            phase_in = PW'(1);
         end
      end else begin
         sum_in = sel_val.sum;
         sel_in = sel_val.selected;
         if (sel_val.hit) begin
            if (!odd_pos) begin
               pair_in = {16'd0, 16'(hit_idx)};
            end else begin
               pair_in = pair_ff | {16'(hit_idx), 16'd0};
            end
            emit = odd_pos || final_pos;
         end
         if (phase_ff >= word_count) begin
            end_pos = 1'b1;
         end else begin
            phase_in = phase_ff + PW'(1);
         end
      end
      if (end_pos) begin
         phase_in = '0;
         pos_in   = final_pos ? 16'd0 : (pos_ff + 16'd1);
      end
   end

   // Config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vec_size_ff   <= 7'd50;
         layer_size_ff <= 16'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_VECTOR_SIZE: vec_size_ff   <= csr_wdata[6:0];
            CSR_LAYER_SIZE:  layer_size_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input register: hold the word until it is processed
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_word_ff <= req_tdata;
      end
   end

   // Sequencing state: advance once per processed word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         pos_ff   <= '0;
         level_ff <= '0;
         sum_ff   <= '0;
         sel_ff   <= 1'b0;
         pair_ff  <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         level_ff <= level_in;
         sum_ff   <= sum_in;
         sel_ff   <= sel_in;
         pair_ff  <= pair_in;
      end
   end

   // Output register: load on emission, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         out_pair_ff <= pair_in;
         out_last_ff <= final_pos;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_pair_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
